[rtl/fpd_pkg.sv]
// package: shared constants, register codes and types of the flow presence detector
`timescale 1ns / 1ps
package fpd_pkg;

	localparam int LONGEST_PERIOD = 256;
	localparam int ADC_BITS       = 12;

	localparam int ENERGY_W    = 18;
	localparam int LEVEL_W     = 12;
	localparam int MARGIN_W    = 14;
	localparam int THR_W       = 18;
	localparam int PERIOD_W    = $clog2(LONGEST_PERIOD) + 1;
	localparam int CNT_W       = PERIOD_W;
	localparam int BANDS       = 6;
	localparam int BAND_K_W    = $clog2(BANDS + 1);
	localparam int BAND_PROD_W = LEVEL_W + $clog2(BANDS + 1);
	localparam int APB_ADDR_W  = 4;
	localparam int APB_DATA_W  = 32;

	localparam logic [LEVEL_W-1:0]  NOISE_FLOOR_RST = LEVEL_W'(609);
	localparam logic [MARGIN_W-1:0] MARGIN_RST      = MARGIN_W'(819);
	localparam logic [LEVEL_W-1:0]  BAND_WIDTH_RST  = LEVEL_W'(585);

	localparam logic [THR_W-1:0] FULL_SCALE4 = THR_W'(((1 << ADC_BITS) - 1) * 4);
	localparam logic [PERIOD_W-1:0] PERIOD_MAX = PERIOD_W'(LONGEST_PERIOD);

	typedef enum logic [1:0] {
		REG_NOISE_FLOOR = 2'd0,
		REG_MARGIN      = 2'd1,
		REG_BAND_WIDTH  = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [LEVEL_W-1:0]  noise_floor;
		logic [MARGIN_W-1:0] margin_quarters;
		logic [LEVEL_W-1:0]  delay_band_width;
	} cfg_t;

	typedef struct packed {
		logic                flow_sample;
		logic [PERIOD_W-1:0] period;
	} class_t;

endpackage

[rtl/fpd_cfg_regs.sv]
// configuration register file behind the apb port
`timescale 1ns / 1ps
module fpd_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fpd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fpd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fpd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	output fpd_pkg::cfg_t                  cfg
);

	fpd_pkg::cfg_t    cfg_q;
	fpd_pkg::reg_idx_t idx;
	logic             wr_en;

	assign idx    = fpd_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.noise_floor      <= fpd_pkg::NOISE_FLOOR_RST;
			cfg_q.margin_quarters  <= fpd_pkg::MARGIN_RST;
			cfg_q.delay_band_width <= fpd_pkg::BAND_WIDTH_RST;
		end else if (wr_en) begin
			unique case (idx)
				fpd_pkg::REG_NOISE_FLOOR: begin
					cfg_q.noise_floor <= pwdata[fpd_pkg::LEVEL_W-1:0];
				end
				fpd_pkg::REG_MARGIN: begin
					cfg_q.margin_quarters <= pwdata[fpd_pkg::MARGIN_W-1:0];
				end
				fpd_pkg::REG_BAND_WIDTH: begin
					cfg_q.delay_band_width <= pwdata[fpd_pkg::LEVEL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			fpd_pkg::REG_NOISE_FLOOR: begin
				prdata = fpd_pkg::APB_DATA_W'(cfg_q.noise_floor);
			end
			fpd_pkg::REG_MARGIN: begin
				prdata = fpd_pkg::APB_DATA_W'(cfg_q.margin_quarters);
			end
			fpd_pkg::REG_BAND_WIDTH: begin
				prdata = fpd_pkg::APB_DATA_W'(cfg_q.delay_band_width);
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

[rtl/fpd_classify.sv]
// hysteresis thresholds, sample classification and persistence period selection
`timescale 1ns / 1ps
module fpd_classify (
	input  fpd_pkg::cfg_t                 cfg,
	input  logic [fpd_pkg::ENERGY_W-1:0]  energy,
	input  logic [fpd_pkg::LEVEL_W-1:0]   reference_level,
	input  logic [fpd_pkg::LEVEL_W-1:0]   delay_knob,
	input  logic                          flow_state,
	output fpd_pkg::class_t               cls
);

	logic [fpd_pkg::THR_W-1:0] nf4;
	logic [fpd_pkg::THR_W-1:0] ref4;
	logic [fpd_pkg::THR_W-1:0] mq;
	logic [fpd_pkg::THR_W-1:0] nf4_up;
	logic [fpd_pkg::THR_W-1:0] ref4_up;
	logic [fpd_pkg::THR_W-1:0] upper;
	logic [fpd_pkg::THR_W-1:0] lower;
	logic                      below_nf;
	logic [fpd_pkg::BAND_K_W-1:0] band;
	logic [fpd_pkg::PERIOD_W-1:0] shifted;

	assign nf4      = fpd_pkg::THR_W'(cfg.noise_floor) << 2;
	assign ref4     = fpd_pkg::THR_W'(reference_level) << 2;
	assign mq       = fpd_pkg::THR_W'(cfg.margin_quarters);
	assign nf4_up   = nf4 + mq;
	assign ref4_up  = ref4 + mq;
	assign below_nf = reference_level < cfg.noise_floor;

	always_comb begin
		if (below_nf) begin
			upper = nf4_up;
		end else if (ref4_up >= fpd_pkg::FULL_SCALE4) begin
			upper = fpd_pkg::FULL_SCALE4;
		end else begin
			upper = ref4_up;
		end
		if (!below_nf && ref4 >= nf4_up) begin
			lower = ref4 - mq;
		end else if (nf4 >= mq) begin
			lower = nf4 - mq;
		end else begin
			lower = '0;
		end
	end

	// band index: how many band edges the knob has passed
	always_comb begin
		logic [fpd_pkg::BAND_PROD_W-1:0] edge_lvl;
		band = '0;
		for (int j = 1; j <= fpd_pkg::BANDS; j++) begin
			edge_lvl = fpd_pkg::BAND_PROD_W'(cfg.delay_band_width) *
				fpd_pkg::BAND_PROD_W'(j);
			if (fpd_pkg::BAND_PROD_W'(delay_knob) >= edge_lvl) begin
				band = band + fpd_pkg::BAND_K_W'(1);
			end
		end
	end

	assign shifted = fpd_pkg::PERIOD_MAX >> band;

	always_comb begin
		cls.period      = (shifted == '0) ? fpd_pkg::PERIOD_W'(1) : shifted;
		cls.flow_sample = flow_state ? (fpd_pkg::THR_W'(energy) > lower)
			: (fpd_pkg::THR_W'(energy) >= upper);
	end

endmodule

[rtl/fpd_persist.sv]
// flow state and run counters with period clamping and persistence check
`timescale 1ns / 1ps
module fpd_persist (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            adv,
	input  fpd_pkg::class_t cls,
	output logic            flow_state,
	output logic            flow_next,
	output logic            changed
);

	logic                      flow_state_q;
	logic [fpd_pkg::CNT_W-1:0] flow_cnt_q;
	logic [fpd_pkg::CNT_W-1:0] idle_cnt_q;
	logic [fpd_pkg::CNT_W-1:0] flow_cnt_d;
	logic [fpd_pkg::CNT_W-1:0] idle_cnt_d;

	always_comb begin
		logic [fpd_pkg::CNT_W-1:0] per;
		logic [fpd_pkg::CNT_W-1:0] mask;
		logic [fpd_pkg::CNT_W-1:0] f;
		logic [fpd_pkg::CNT_W-1:0] i;
		per  = fpd_pkg::CNT_W'(cls.period);
		mask = per - fpd_pkg::CNT_W'(1);
		f    = flow_cnt_q;
		i    = idle_cnt_q;
		// clamp when the period has shrunk
		if (f > per) begin
			f = mask;
			i = '0;
		end else if (i > per) begin
			i = mask;
			f = '0;
		end
		if (cls.flow_sample) begin
			f = f + fpd_pkg::CNT_W'(1);
			i = '0;
		end else begin
			i = i + fpd_pkg::CNT_W'(1);
			f = '0;
		end
		flow_next = flow_state_q;
		if (f != '0 && (f & mask) == '0) begin
			flow_next = 1'b1;
			f         = '0;
		end else if (i != '0 && (i & mask) == '0) begin
			flow_next = 1'b0;
			i         = '0;
		end
		flow_cnt_d = f;
		idle_cnt_d = i;
	end

	assign changed    = flow_next != flow_state_q;
	assign flow_state = flow_state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_state_q <= 1'b0;
			flow_cnt_q   <= '0;
			idle_cnt_q   <= '0;
		end else if (adv) begin
			flow_state_q <= flow_next;
			flow_cnt_q   <= flow_cnt_d;
			idle_cnt_q   <= idle_cnt_d;
		end
	end

	a_one_run_active: assert property (@(posedge clk) disable iff (!arst_n)
		!(flow_cnt_q != '0 && idle_cnt_q != '0))
		else $error("flow and idle run counts both nonzero");

	a_change_toggles: assert property (@(posedge clk) disable iff (!arst_n)
		adv && changed |=> flow_state_q != $past(flow_state_q))
		else $error("reported state change did not toggle the state");

	a_hold_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(flow_state_q) && $stable(flow_cnt_q) && $stable(idle_cnt_q))
		else $error("persistence state moved without a beat");

	a_no_change_no_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !changed |=> flow_state_q == $past(flow_state_q))
		else $error("state toggled without a reported change");

endmodule

[rtl/flow_presence_hysteresis_detector_top.sv]
// top level of the flow presence hysteresis detector
`timescale 1ns / 1ps
// One sample enters per clock cycle while the input is not stalled: the
// sample is captured in an input register, classified against the
// hysteresis thresholds and folded into the persistence counters, and the
// flow state is held in an output register. The rate is set by the state
// update, which closes on itself from one sample to the next. While the
// output beat is stalled the block still holds one more sample in its input
// register before it stalls the input. The user must write the configuration
// registers over the apb port only while no sample is in flight; the block
// itself does not enforce this.
module flow_presence_hysteresis_detector_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [fpd_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [fpd_pkg::APB_DATA_W-1:0] pwdata,
	output logic [fpd_pkg::APB_DATA_W-1:0] prdata,
	output logic                           pready,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [fpd_pkg::ENERGY_W-1:0]   energy,
	input  logic [fpd_pkg::LEVEL_W-1:0]    reference_level,
	input  logic [fpd_pkg::LEVEL_W-1:0]    delay_knob,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           flow_present,
	output logic                           state_changed
);

	fpd_pkg::cfg_t   cfg;
	fpd_pkg::class_t cls;

	logic                         valid_s1;
	logic [fpd_pkg::ENERGY_W-1:0] energy_s1;
	logic [fpd_pkg::LEVEL_W-1:0]  reference_level_s1;
	logic [fpd_pkg::LEVEL_W-1:0]  delay_knob_s1;
	logic                         out_valid_q;
	logic                         flow_present_q;
	logic                         state_changed_q;
	logic                         adv;
	logic                         flow_state;
	logic                         flow_next;
	logic                         changed;

	fpd_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	fpd_classify u_classify (
		.cfg             (cfg),
		.energy          (energy_s1),
		.reference_level (reference_level_s1),
		.delay_knob      (delay_knob_s1),
		.flow_state      (flow_state),
		.cls             (cls)
	);

	fpd_persist u_persist (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.cls        (cls),
		.flow_state (flow_state),
		.flow_next  (flow_next),
		.changed    (changed)
	);

	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			energy_s1          <= energy;
			reference_level_s1 <= reference_level;
			delay_knob_s1      <= delay_knob;
		end
		if (adv) begin
			flow_present_q  <= flow_next;
			state_changed_q <= changed;
		end
	end

	assign out_valid     = out_valid_q;
	assign flow_present  = flow_present_q;
	assign state_changed = state_changed_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with a free input register");

	a_out_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q && flow_present_q == flow_state)
		else $error("output beat disagrees with the flow state");

endmodule

[dv/flow_presence_hysteresis_detector_top_tb.sv]
// testbench: flow presence hysteresis detector with its own predictor and scoreboard
`timescale 1ns / 1ps
module flow_presence_hysteresis_detector_top_tb;
	import fpd_pkg::*;

	typedef struct {
		logic [ENERGY_W-1:0] energy;
		logic [LEVEL_W-1:0]  reference_level;
		logic [LEVEL_W-1:0]  delay_knob;
	} sample_t;

	typedef struct {
		logic flow_present;
		logic state_changed;
	} flow_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [ENERGY_W-1:0]   energy = '0;
	logic [LEVEL_W-1:0]    reference_level = '0;
	logic [LEVEL_W-1:0]    delay_knob = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  flow_present;
	logic                  state_changed;

	sample_t      pending_q[$];
	flow_result_t flow_expect_q[$];
	int unsigned  sender_idle_pct = 0;
	int unsigned  recv_stall_pct = 0;
	int unsigned  mismatch_count = 0;

	// predictor copy of configuration and detector state
	int unsigned noise_floor_cfg = NOISE_FLOOR_RST;
	int unsigned margin_cfg      = MARGIN_RST;
	int unsigned band_width_cfg  = BAND_WIDTH_RST;
	logic        flow_state_m    = 1'b0;
	int unsigned flow_run        = 0;
	int unsigned idle_run        = 0;

	flow_presence_hysteresis_detector_top u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.energy         (energy),
		.reference_level(reference_level),
		.delay_knob     (delay_knob),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.flow_present   (flow_present),
		.state_changed  (state_changed)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned persistence_period(int unsigned knob);
		int unsigned band;
		int unsigned p;
		band = 0;
		for (int unsigned j = 1; j <= BANDS; j++) begin
			if (knob >= j * band_width_cfg)
				band++;
		end
		p = LONGEST_PERIOD >> band;
		return (p == 0) ? 1 : p;
	endfunction

	function automatic int unsigned upper_quarters(int unsigned ref_lvl);
		int unsigned v;
		if (ref_lvl < noise_floor_cfg)
			return noise_floor_cfg * 4 + margin_cfg;
		v = ref_lvl * 4 + margin_cfg;
		return (v >= FULL_SCALE4) ? FULL_SCALE4 : v;
	endfunction

	function automatic int unsigned lower_quarters(int unsigned ref_lvl);
		int unsigned nf4;
		nf4 = noise_floor_cfg * 4;
		if (ref_lvl >= noise_floor_cfg && ref_lvl * 4 >= nf4 + margin_cfg)
			return ref_lvl * 4 - margin_cfg;
		return (nf4 >= margin_cfg) ? nf4 - margin_cfg : 0;
	endfunction

	task automatic predict_flow(sample_t s);
		int unsigned  p;
		logic         was;
		logic         flow_hit;
		flow_result_t res;
		p = persistence_period(s.delay_knob);
		was = flow_state_m;
		// shorter period: clamp the running count
		if (flow_run > p) begin
			flow_run = p - 1;
			idle_run = 0;
		end else if (idle_run > p) begin
			idle_run = p - 1;
			flow_run = 0;
		end
		if (flow_state_m)
			flow_hit = s.energy > lower_quarters(s.reference_level);
		else
			flow_hit = !(s.energy < upper_quarters(s.reference_level));
		if (flow_hit) begin
			flow_run++;
			idle_run = 0;
		end else begin
			idle_run++;
			flow_run = 0;
		end
		if (flow_run != 0 && flow_run % p == 0) begin
			flow_state_m = 1'b1;
			flow_run = 0;
		end else if (idle_run != 0 && idle_run % p == 0) begin
			flow_state_m = 1'b0;
			idle_run = 0;
		end
		res.flow_present = flow_state_m;
		res.state_changed = flow_state_m != was;
		flow_expect_q.push_back(res);
	endtask

	task automatic report_mismatch(string msg);
		$display("%0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : driver
		sample_t cur;
		if (in_valid && !in_stall) begin
			cur.energy = energy;
			cur.reference_level = reference_level;
			cur.delay_knob = delay_knob;
			predict_flow(cur);
		end
		if (!in_valid || !in_stall) begin
			if (arst_n && pending_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				cur = pending_q.pop_front();
				in_valid <= 1'b1;
				energy <= cur.energy;
				reference_level <= cur.reference_level;
				delay_knob <= cur.delay_knob;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin : monitor
		flow_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (flow_expect_q.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				want = flow_expect_q.pop_front();
				if (flow_present !== want.flow_present)
					report_mismatch($sformatf("flow_present got %b want %b",
						flow_present, want.flow_present));
				if (state_changed !== want.state_changed)
					report_mismatch($sformatf("state_changed got %b want %b",
						state_changed, want.state_changed));
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic write_register(reg_idx_t idx, logic [APB_DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			REG_NOISE_FLOOR: noise_floor_cfg = value[LEVEL_W-1:0];
			REG_MARGIN:      margin_cfg = value[MARGIN_W-1:0];
			REG_BAND_WIDTH:  band_width_cfg = value[LEVEL_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(int unsigned nf, int unsigned margin, int unsigned bw);
		write_register(REG_NOISE_FLOOR, nf);
		write_register(REG_MARGIN, margin);
		write_register(REG_BAND_WIDTH, bw);
	endtask

	task automatic queue_sample(int unsigned e, int unsigned r, int unsigned k);
		sample_t s;
		s.energy = e;
		s.reference_level = r;
		s.delay_knob = k;
		pending_q.push_back(s);
	endtask

	task automatic wait_drained();
		do
			@(posedge clk);
		while (pending_q.size() != 0 || in_valid || flow_expect_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic int unsigned run_energy(logic want_flow, int unsigned r);
		int unsigned up;
		int unsigned lo;
		up = upper_quarters(r);
		lo = lower_quarters(r);
		case ($urandom_range(3))
			0: return want_flow ? $urandom_range(262143, 32761) : $urandom_range(lo, 0);
			1: return want_flow ? up : ((up == 0) ? 0 : up - 1);
			2: return want_flow ? lo + 1 : lo;
			default: return want_flow ? $urandom_range(262143, up) : 0;
		endcase
	endfunction

	// runs of consistent samples with random content, plus some noise
	task automatic queue_runs(int unsigned count);
		int unsigned queued;
		int unsigned r;
		int unsigned k;
		int unsigned p;
		int unsigned len;
		logic        want_flow;
		queued = 0;
		while (queued < count) begin
			if ($urandom_range(99) < 20) begin
				queue_sample($urandom_range(262143, 0), $urandom_range(4095, 0),
					$urandom_range(4095, 0));
				queued++;
			end else begin
				r = ($urandom_range(9) == 0) ? noise_floor_cfg : $urandom_range(4095, 0);
				case ($urandom_range(3))
					0, 1: k = 4095;
					2: k = $urandom_range(4095, 0);
					default: k = (band_width_cfg * $urandom_range(6, 1) -
						$urandom_range(1, 0)) & 12'hfff;
				endcase
				p = persistence_period(k);
				if (p > 64 && $urandom_range(3) != 0)
					len = $urandom_range(8, 1);
				else if ($urandom_range(9) < 6)
					len = p + $urandom_range(1, 0);
				else
					len = $urandom_range(p, 1);
				want_flow = $urandom_range(1, 0);
				for (int unsigned i = 0; i < len && queued < count; i++) begin
					queue_sample(run_energy(want_flow, r), r, k);
					queued++;
				end
			end
		end
	endtask

	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset configuration: full scale flow turns on at the shortest period
		repeat (4) queue_sample(262143, 4095, 4095);
		// period completed while already in flow
		repeat (4) queue_sample(262143, 4095, 4095);
		// reference below noise floor, zero energy turns flow off
		repeat (4) queue_sample(0, 0, 4095);
		// energy exactly on the upper threshold, longest period
		repeat (5) queue_sample(2000 * 4 + 819, 2000, 0);
		// period shrinks under a long run
		repeat (2) queue_sample(262143, 2000, 4095);
		// energy exactly on the lower threshold while in flow
		queue_sample(2000 * 4 - 819, 2000, 2000);
		queue_sample(1, 4095, 585);
		queue_sample(262143, 0, 584);
		queue_sample(0, 4095, 0);
		wait_drained();

		configure(0, 16380, 1);
		sender_idle_pct = 69;
		queue_runs(250);
		wait_drained();

		configure(4095, 0, 4095);
		sender_idle_pct = 0;
		recv_stall_pct = 69;
		queue_runs(250);
		wait_drained();

		// zero band width selects the shortest period for every knob
		configure($urandom_range(4095, 0), $urandom_range(16383, 0), 0);
		sender_idle_pct = 34;
		recv_stall_pct = 34;
		queue_runs(250);
		wait_drained();

		configure($urandom_range(1200, 0), $urandom_range(4000, 0), $urandom_range(700, 1));
		sender_idle_pct = 0;
		recv_stall_pct = 0;
		queue_runs(250);
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin : watchdog
		#10ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
